### src/pmwb_pkg.sv
// ----------------------------------------------------------------------------
// pmwb_pkg: shared types and constants for the particle move and wall bounce.
// Holds the register indexes, the sequencer states and the CORDIC table.
// ----------------------------------------------------------------------------
package pmwb_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int FRAC_BITS_DEF    = 16;
  localparam int CFG_IDX_W        = 3;
  localparam int CFG_DATA_W       = 16;
  localparam logic [63:0] CORDIC_GAIN_Q30 = 64'd652032874;
  localparam logic [15:0] HALF_TURN = 16'h8000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCREEN_W   = 3'd0,
    REG_SCREEN_H   = 3'd1,
    REG_RADIUS     = 3'd2,
    REG_SPEED      = 3'd3,
    REG_START_X    = 3'd4,
    REG_START_Y    = 3'd5,
    REG_START_HEAD = 3'd6,
    REG_SPARE      = 3'd7
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LEN,
    ST_COR1,
    ST_MULX,
    ST_MULY,
    ST_CLAMP,
    ST_COR2,
    ST_PUSHX,
    ST_COR3,
    ST_PUSHY,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic        start;
    logic [15:0] angle;
  } cor_req_t;

  function automatic logic [31:0] atan_entry(input logic [4:0] i);
    logic [31:0] v;
    unique case (i)
      5'd0:  v = 32'd536870912;
      5'd1:  v = 32'd316933406;
      5'd2:  v = 32'd167458907;
      5'd3:  v = 32'd85004756;
      5'd4:  v = 32'd42667331;
      5'd5:  v = 32'd21354465;
      5'd6:  v = 32'd10679838;
      5'd7:  v = 32'd5340245;
      5'd8:  v = 32'd2670163;
      5'd9:  v = 32'd1335086;
      5'd10: v = 32'd667544;
      5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;
      5'd13: v = 32'd83443;
      5'd14: v = 32'd41721;
      5'd15: v = 32'd20860;
      5'd16: v = 32'd10430;
      5'd17: v = 32'd5215;
      5'd18: v = 32'd2607;
      5'd19: v = 32'd1303;
      5'd20: v = 32'd651;
      5'd21: v = 32'd325;
      5'd22: v = 32'd162;
      5'd23: v = 32'd81;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

### src/pmwb_stream_if.sv
// ----------------------------------------------------------------------------
// pmwb_stream_if: valid/ready channel carrying one payload.
// A transaction completes on a clock edge with valid and ready both high.
// ----------------------------------------------------------------------------
interface pmwb_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### src/pmwb_cordic.sv
// ----------------------------------------------------------------------------
// pmwb_cordic: iterative rotation-mode CORDIC, one micro-rotation per cycle.
// Returns cos and sin of a 16-bit binary angle with FRAC_BITS fraction bits.
// ----------------------------------------------------------------------------
module pmwb_cordic #(
  parameter int CORDIC_STEPS = pmwb_pkg::CORDIC_STEPS_DEF,
  parameter int FRAC_BITS    = pmwb_pkg::FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  pmwb_pkg::cor_req_t  req,
  output logic                done,
  output logic signed [FRAC_BITS+2:0] cos_o,
  output logic signed [FRAC_BITS+2:0] sin_o
);
  localparam int VW = FRAC_BITS + 3;
  localparam int CW = $clog2(CORDIC_STEPS + 1);

  logic signed [VW-1:0] x_r, x_nxt, y_r, y_nxt;
  logic signed [32:0]   z_r, z_nxt;
  logic                 flip_r, flip_nxt;
  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic [31:0]          a;
  logic                 fl;
  logic signed [VW-1:0] dx, dy;
  logic signed [32:0]   at;

  always_comb begin
    a = {req.angle, 16'h0000};
    fl = a[31] ^ a[30];
    dx = y_r >>> cnt_r;
    dy = x_r >>> cnt_r;
    at = $signed({1'b0, pmwb_pkg::atan_entry(5'(cnt_r))});
    x_nxt = x_r;
    y_nxt = y_r;
    z_nxt = z_r;
    flip_nxt = flip_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt = cnt_r;
    if (req.start) begin
      flip_nxt = fl;
      z_nxt = $signed({fl ? ~a[31] : a[31], fl ? ~a[31] : a[31], a[30:0]});
      x_nxt = VW'($signed(pmwb_pkg::CORDIC_GAIN_Q30 >> (30 - FRAC_BITS)));
      y_nxt = '0;
      cnt_nxt = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!z_r[32]) begin
        x_nxt = x_r - dx;
        y_nxt = y_r + dy;
        z_nxt = z_r - at;
      end else begin
        x_nxt = x_r + dx;
        y_nxt = y_r - dy;
        z_nxt = z_r + at;
      end
      cnt_nxt = cnt_r + CW'(1);
      if (cnt_r == CW'(CORDIC_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    z_r    <= z_nxt;
    flip_r <= flip_nxt;
  end

  assign done  = done_r;
  assign cos_o = flip_r ? -x_r : x_r;
  assign sin_o = flip_r ? -y_r : y_r;
endmodule

### src/particle_move_and_wall_bounce.sv
// ----------------------------------------------------------------------------
// particle_move_and_wall_bounce: one particle advanced once per tick.
//
// The input channel takes one tick transaction carrying time_step (Q0.16 s).
// Each tick moves the particle along its heading, clamps it into the screen
// and reflects it off the side walls and the top or bottom, yielding one
// result transaction with the new position, heading and bounce flags.
// A sequencer drives one iterative CORDIC unit and a multiplier shared by the
// move and push products. A tick needs one evaluation plus one per bounce.
// in_ready is high only while idle; a new tick is taken once the previous
// result has been handed over to the output register. The result stays in
// the output register while out_ready is low. Reset sets the registers to
// their reset values and the particle to the origin with heading zero.
// Writes to start_x, start_y or start_heading reload the particle state;
// the user must write only while the block is idle; it is not enforced.
// ----------------------------------------------------------------------------
module particle_move_and_wall_bounce #(
  parameter int CORDIC_STEPS = pmwb_pkg::CORDIC_STEPS_DEF,
  parameter int FRAC_BITS    = pmwb_pkg::FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] in_time_step,
  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [31:0] out_pos_x,
  output logic signed [31:0] out_pos_y,
  output logic [15:0] out_heading_out,
  output logic        out_side_bounce,
  output logic        out_floor_bounce,
  input  logic        cfg_we,
  input  logic [pmwb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pmwb_pkg::CFG_DATA_W-1:0] cfg_data
);
  localparam int TW = FRAC_BITS + 3;

  pmwb_pkg::state_t state_r, state_nxt;
  logic [11:0] scr_w_r, scr_h_r;
  logic [7:0]  rad_r;
  logic [15:0] speed_r;
  logic [31:0] px_r, py_r;
  logic [15:0] head_r;
  logic [15:0] step_r;
  logic [27:0] len_r;
  logic signed [31:0] x_r, y_r;
  logic        side_r, floor_r;
  logic signed [63:0] prod_r;
  logic        ov_r;

  pmwb_pkg::cor_req_t creq;
  logic        cdone;
  logic signed [TW-1:0] c_cos, c_sin;

  pmwb_cordic #(.CORDIC_STEPS(CORDIC_STEPS), .FRAC_BITS(FRAC_BITS)) u_cordic (
    .clk(clk), .rst_n(rst_n), .req(creq), .done(cdone), .cos_o(c_cos), .sin_o(c_sin)
  );

  logic signed [33:0] rad_q, w_q, h_q, wl_q, hl_q;
  logic signed [33:0] cx, cy;
  logic signed [35:0] mul_a;
  logic signed [TW-1:0] mul_b;
  logic signed [63:0] mul_p;
  logic [63:0] pmag;
  logic signed [31:0] pushv;
  logic signed [31:0] stepv;

  assign rad_q = $signed({10'd0, rad_r, 16'd0});
  assign w_q   = $signed({6'd0, scr_w_r, 16'd0});
  assign h_q   = $signed({6'd0, scr_h_r, 16'd0});
  assign wl_q  = w_q - rad_q;
  assign hl_q  = h_q - rad_q;
  assign cx    = 34'(x_r);
  assign cy    = 34'(y_r);

  always_comb begin
    mul_a = $signed({8'd0, len_r});
    mul_b = (state_r == pmwb_pkg::ST_MULX || state_r == pmwb_pkg::ST_COR3) ? c_sin : c_cos;
    if (state_r == pmwb_pkg::ST_COR2 || state_r == pmwb_pkg::ST_COR3) begin
      mul_a = $signed({8'd0, len_r}) + 36'(rad_q);
    end
    mul_p = 64'(mul_a) * 64'(mul_b);
    pmag  = prod_r[63] ? 64'(-prod_r) : 64'(prod_r);
    pmag  = pmag >> (16 + FRAC_BITS);
    pushv = prod_r[63] ? -{pmag[15:0], 16'd0} : {pmag[15:0], 16'd0};
    stepv = 32'(prod_r >>> FRAC_BITS);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pmwb_pkg::ST_IDLE:  if (in_valid) state_nxt = pmwb_pkg::ST_LEN;
      pmwb_pkg::ST_LEN:   state_nxt = pmwb_pkg::ST_COR1;
      pmwb_pkg::ST_COR1:  if (cdone) state_nxt = pmwb_pkg::ST_MULX;
      pmwb_pkg::ST_MULX:  state_nxt = pmwb_pkg::ST_MULY;
      pmwb_pkg::ST_MULY:  state_nxt = pmwb_pkg::ST_CLAMP;
      pmwb_pkg::ST_CLAMP: begin
        if (cx <= rad_q || cx >= wl_q) state_nxt = pmwb_pkg::ST_COR2;
        else if (cy <= rad_q || cy >= hl_q) state_nxt = pmwb_pkg::ST_COR3;
        else state_nxt = pmwb_pkg::ST_DONE;
      end
      pmwb_pkg::ST_COR2:  if (cdone) state_nxt = pmwb_pkg::ST_PUSHX;
      pmwb_pkg::ST_PUSHX: begin
        if (cy <= rad_q || cy >= hl_q) state_nxt = pmwb_pkg::ST_COR3;
        else state_nxt = pmwb_pkg::ST_DONE;
      end
      pmwb_pkg::ST_COR3:  if (cdone) state_nxt = pmwb_pkg::ST_PUSHY;
      pmwb_pkg::ST_PUSHY: state_nxt = pmwb_pkg::ST_DONE;
      pmwb_pkg::ST_DONE:  if (!ov_r || out_ready) state_nxt = pmwb_pkg::ST_IDLE;
      default:            state_nxt = pmwb_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = (state_r == pmwb_pkg::ST_IDLE);
    creq.start = 1'b0;
    creq.angle = head_r;
    unique case (state_r)
      pmwb_pkg::ST_LEN: creq.start = 1'b1;
      pmwb_pkg::ST_CLAMP: begin
        creq.start = 1'b1;
        if (cx <= rad_q || cx >= wl_q) creq.angle = pmwb_pkg::HALF_TURN - head_r;
        else creq.angle = 16'd0 - head_r;
      end
      pmwb_pkg::ST_PUSHX: begin
        creq.start = 1'b1;
        creq.angle = 16'd0 - head_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pmwb_pkg::ST_IDLE;
      scr_w_r <= 12'd1280;
      scr_h_r <= 12'd720;
      rad_r   <= 8'd1;
      speed_r <= '0;
      px_r    <= '0;
      py_r    <= '0;
      head_r  <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (pmwb_pkg::cfg_idx_t'(cfg_index))
          pmwb_pkg::REG_SCREEN_W:   scr_w_r <= cfg_data[11:0];
          pmwb_pkg::REG_SCREEN_H:   scr_h_r <= cfg_data[11:0];
          pmwb_pkg::REG_RADIUS:     rad_r   <= cfg_data[7:0];
          pmwb_pkg::REG_SPEED:      speed_r <= cfg_data;
          pmwb_pkg::REG_START_X:    px_r    <= {4'd0, cfg_data[11:0], 16'd0};
          pmwb_pkg::REG_START_Y:    py_r    <= {4'd0, cfg_data[11:0], 16'd0};
          pmwb_pkg::REG_START_HEAD: head_r  <= cfg_data;
          default: ;
        endcase
      end
      if (out_valid && out_ready && state_r != pmwb_pkg::ST_DONE) ov_r <= 1'b0;
      unique case (state_r)
        pmwb_pkg::ST_CLAMP: begin
          if (cx <= rad_q || cx >= wl_q) head_r <= pmwb_pkg::HALF_TURN - head_r;
          else if (cy <= rad_q || cy >= hl_q) head_r <= 16'd0 - head_r;
        end
        pmwb_pkg::ST_PUSHX: if (cy <= rad_q || cy >= hl_q) head_r <= 16'd0 - head_r;
        pmwb_pkg::ST_DONE: begin
          if (!ov_r || out_ready) begin
            ov_r <= 1'b1;
            px_r <= x_r;
            py_r <= y_r;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      pmwb_pkg::ST_IDLE: begin
        step_r  <= in_time_step;
        side_r  <= 1'b0;
        floor_r <= 1'b0;
      end
      pmwb_pkg::ST_LEN: len_r <= 28'(({16'd0, speed_r} * {16'd0, step_r}) >> 4);
      pmwb_pkg::ST_COR1: if (cdone) prod_r <= mul_p;
      pmwb_pkg::ST_MULX: begin
        x_r    <= $signed(px_r) + stepv;
        prod_r <= mul_p;
      end
      pmwb_pkg::ST_MULY: y_r <= $signed(py_r) + stepv;
      pmwb_pkg::ST_CLAMP: begin
        if (x_r < 0) x_r <= 32'(rad_q);
        else if (cx > w_q) x_r <= 32'(wl_q);
        if (y_r < 0) y_r <= 32'(rad_q);
        else if (cy > h_q) y_r <= 32'(hl_q);
      end
      pmwb_pkg::ST_COR2: if (cdone) begin
        side_r <= 1'b1;
        prod_r <= mul_p;
      end
      pmwb_pkg::ST_COR3: if (cdone) begin
        floor_r <= 1'b1;
        prod_r  <= mul_p;
      end
      default: ;
    endcase
    if (state_r == pmwb_pkg::ST_PUSHX) x_r <= x_r + pushv;
    if (state_r == pmwb_pkg::ST_PUSHY) y_r <= y_r + pushv;
    if (state_r == pmwb_pkg::ST_DONE && (!ov_r || out_ready)) begin
      out_pos_x        <= x_r;
      out_pos_y        <= y_r;
      out_heading_out  <= head_r;
      out_side_bounce  <= side_r;
      out_floor_bounce <= floor_r;
    end
  end

  assign out_valid = ov_r;
endmodule

### tb/sv/particle_move_and_wall_bounce_test.sv
// ----------------------------------------------------------------------------
// particle_move_and_wall_bounce_test: self-checking bench for the particle mover.
// Tick transactions are sent and each result transaction is checked against a
// behavioural model of the CORDIC move, the clamp and the wall bounces. The
// model is run over directed corner settings first and then over random ones.
// ----------------------------------------------------------------------------
module particle_move_and_wall_bounce_test;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic [15:0]        heading;
    logic               side_hit;
    logic               floor_hit;
  } motion_t;

  localparam longint ARCTAN [16] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335086, 667544, 333772,
    166886, 83443, 41721, 20860
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  pmwb_pkg::cfg_idx_t cfg_index = pmwb_pkg::REG_SCREEN_W;
  logic [pmwb_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  pmwb_stream_if #(.payload_t(logic [15:0])) tick_ch ();
  pmwb_stream_if #(.payload_t(motion_t))     motion_ch ();

  logic signed [31:0] dut_x, dut_y;
  logic [15:0] dut_head;
  logic dut_side, dut_floor;
  assign motion_ch.data = '{dut_x, dut_y, dut_head, dut_side, dut_floor};

  particle_move_and_wall_bounce uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (tick_ch.valid),
    .in_ready         (tick_ch.ready),
    .in_time_step     (tick_ch.data),
    .out_valid        (motion_ch.valid),
    .out_ready        (motion_ch.ready),
    .out_pos_x        (dut_x),
    .out_pos_y        (dut_y),
    .out_heading_out  (dut_head),
    .out_side_bounce  (dut_side),
    .out_floor_bounce (dut_floor),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Model state and settings.
  int unsigned scr_w = 1280, scr_h = 720, radius = 1, spd = 0;
  int pos_x_q = 0, pos_y_q = 0;
  logic [15:0] head_q = '0;

  logic [15:0] ticks_pending [$];
  motion_t     motion_expected [$];
  int errors = 0;
  int results_seen = 0;
  int send_gap = 0;
  int hold_cnt = 0;

  function automatic void sincos(input logic [15:0] h, output longint c, output longint s);
    logic [31:0] a;
    logic [31:0] t;
    logic flip;
    longint z, x, y, dx, dy;
    a = {h, 16'h0000};
    t = a + 32'h4000_0000;
    flip = t[31];
    if (flip) a = a + 32'h8000_0000;
    z = longint'(signed'(a));
    x = longint'(pmwb_pkg::CORDIC_GAIN_Q30 >> 14);
    y = 0;
    for (int i = 0; i < 16; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx; y = y + dy; z = z - ARCTAN[i];
      end else begin
        x = x + dx; y = y - dy; z = z + ARCTAN[i];
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic longint wall_push(input longint d, input longint t);
    longint p, m;
    p = d * t;
    m = (p < 0) ? -p : p;
    m = (m >> 32) * 65536;
    return (p < 0) ? -m : m;
  endfunction

  function automatic motion_t advance_particle(input logic [15:0] step);
    longint len, rad, w, hg, push_d, c, s, x, y;
    motion_t r;
    len  = (longint'(spd) * longint'(step)) >>> 4;
    rad  = longint'(radius) * 65536;
    w    = longint'(scr_w) * 65536;
    hg   = longint'(scr_h) * 65536;
    push_d = len + rad;
    r.side_hit = 1'b0;
    r.floor_hit = 1'b0;
    sincos(head_q, c, s);
    x = longint'(int'(longint'(pos_x_q) + ((len * c) >>> 16)));
    y = longint'(int'(longint'(pos_y_q) + ((len * s) >>> 16)));
    if (x < 0) x = rad;
    else if (x > w) x = w - rad;
    if (y < 0) y = rad;
    else if (y > hg) y = hg - rad;
    if (x <= rad || x >= w - rad) begin
      r.side_hit = 1'b1;
      head_q = pmwb_pkg::HALF_TURN - head_q;
      sincos(head_q, c, s);
      x = x + wall_push(push_d, c);
    end
    if (y <= rad || y >= hg - rad) begin
      r.floor_hit = 1'b1;
      head_q = 16'h0000 - head_q;
      sincos(head_q, c, s);
      y = y + wall_push(push_d, s);
    end
    pos_x_q = int'(x);
    pos_y_q = int'(y);
    r.pos_x = pos_x_q;
    r.pos_y = pos_y_q;
    r.heading = head_q;
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  // Sender.
  always @(posedge clk) begin
    if (!rst_n) begin
      tick_ch.valid <= 1'b0;
      tick_ch.data  <= '0;
    end else begin
      if (tick_ch.valid && tick_ch.ready)
        motion_expected.push_back(advance_particle(tick_ch.data));
      if (!tick_ch.valid || tick_ch.ready) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          tick_ch.valid <= 1'b0;
        end else if (ticks_pending.size() > 0) begin
          tick_ch.valid <= 1'b1;
          tick_ch.data <= ticks_pending.pop_front();
          send_gap <= pick_gap();
        end else begin
          tick_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver hold-off counter.
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_cnt <= 0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
    end else if (results_seen == 60 && motion_ch.valid && motion_ch.ready) begin
      hold_cnt <= 400;
    end else if ($urandom_range(0, 299) == 0) begin
      hold_cnt <= $urandom_range(50, 150);
    end
  end

  // Receiver and checker.
  always @(posedge clk) begin
    motion_t want;
    if (!rst_n) begin
      motion_ch.ready <= 1'b0;
    end else begin
      if (motion_ch.valid && motion_ch.ready) begin
        results_seen <= results_seen + 1;
        if (motion_expected.size() == 0) begin
          errors = errors + 1;
          if (errors <= 10)
            $display("unexpected result transaction: %p", motion_ch.data);
        end else begin
          want = motion_expected.pop_front();
          if (motion_ch.data !== want) begin
            errors = errors + 1;
            if (errors <= 10)
              $display("mismatch: x %h/%h y %h/%h head %h/%h side %b/%b floor %b/%b",
                       want.pos_x, motion_ch.data.pos_x, want.pos_y, motion_ch.data.pos_y,
                       want.heading, motion_ch.data.heading, want.side_hit,
                       motion_ch.data.side_hit, want.floor_hit, motion_ch.data.floor_hit);
          end
        end
      end
      if (hold_cnt > 0) begin
        motion_ch.ready <= 1'b0;
      end else begin
        case (pick_gap())
          0: motion_ch.ready <= 1'b1;
          default: motion_ch.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  task automatic write_reg(input pmwb_pkg::cfg_idx_t idx, input int unsigned value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[pmwb_pkg::CFG_DATA_W-1:0];
    case (idx)
      pmwb_pkg::REG_SCREEN_W:   scr_w = value & 12'hFFF;
      pmwb_pkg::REG_SCREEN_H:   scr_h = value & 12'hFFF;
      pmwb_pkg::REG_RADIUS:     radius = value & 8'hFF;
      pmwb_pkg::REG_SPEED:      spd = value & 16'hFFFF;
      pmwb_pkg::REG_START_X:    pos_x_q = int'((value & 12'hFFF) << 16);
      pmwb_pkg::REG_START_Y:    pos_y_q = int'((value & 12'hFFF) << 16);
      pmwb_pkg::REG_START_HEAD: head_q = value[15:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic setup(input int unsigned w, h, r, v, x0, y0, hd);
    write_reg(pmwb_pkg::REG_SCREEN_W, w);
    write_reg(pmwb_pkg::REG_SCREEN_H, h);
    write_reg(pmwb_pkg::REG_RADIUS, r);
    write_reg(pmwb_pkg::REG_SPEED, v);
    write_reg(pmwb_pkg::REG_START_X, x0);
    write_reg(pmwb_pkg::REG_START_Y, y0);
    write_reg(pmwb_pkg::REG_START_HEAD, hd);
  endtask

  task automatic drain();
    wait (ticks_pending.size() == 0 && !tick_ch.valid && motion_expected.size() == 0);
    repeat (80) @(posedge clk);
  endtask

  initial begin
    int unsigned w, h;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: defaults, then corner settings.
    ticks_pending.push_back(16'h0000);
    ticks_pending.push_back(16'hFFFF);
    drain();
    setup(1280, 720, 4, 1600, 640, 360, 16'h0000);
    ticks_pending.push_back(16'hFFFF);
    ticks_pending.push_back(16'h5555);
    ticks_pending.push_back(16'hAAAA);
    drain();
    setup(4095, 4095, 0, 65535, 4095, 4095, 16'hFFFF);
    ticks_pending.push_back(16'hFFFF);
    ticks_pending.push_back(16'h0000);
    ticks_pending.push_back(16'hFFFF);
    drain();
    setup(1, 1, 255, 65535, 0, 0, 16'h8000);
    ticks_pending.push_back(16'hFFFF);
    ticks_pending.push_back(16'h0001);
    drain();
    foreach (ARCTAN[i]) if (i < 4) begin
      setup(800, 600, 10, 32000, 400, 300, 16'h4000 * i + 16'h2000 * (i & 1));
      ticks_pending.push_back(16'hFFFF);
      ticks_pending.push_back(16'h8000);
      drain();
    end

    // Random part.
    for (int n = 0; n < 1900; ) begin
      int cnt;
      w = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 20) : $urandom_range(50, 4095);
      h = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 20) : $urandom_range(50, 4095);
      setup(w, h,
            ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 16),
            ($urandom_range(0, 4) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 8000),
            $urandom_range(0, 4095) % (w + 1), $urandom_range(0, 4095) % (h + 1),
            $urandom_range(0, 65535));
      cnt = $urandom_range(20, 80);
      for (int k = 0; k < cnt; k++)
        ticks_pending.push_back(($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                           : $urandom_range(0, 4000));
      n = n + cnt;
      drain();
    end

    if (errors == 0 && motion_expected.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
